@@ hdl/limit_order_book_matcher_defines.svh @@
// Assertion macros shared by the order book matcher modules.
`ifndef LIMIT_ORDER_BOOK_MATCHER_DEFINES_SVH
`define LIMIT_ORDER_BOOK_MATCHER_DEFINES_SVH
`ifndef SYNTHESIS
`define LOBM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LOBM_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define LOBM_ASSERT(lbl, clk, rst_n, prop, msg)
`define LOBM_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

@@ hdl/lobm_pkg.sv @@
// Types and constants of the limit order book matcher.
`timescale 1ns / 1ps
package lobm_pkg;

  localparam int unsigned ORDER_SLOTS = 32;
  localparam int unsigned IDX_W = $clog2(ORDER_SLOTS);

  typedef logic [IDX_W-1:0] idx_t;

  localparam logic [1:0] FUNC_NEW    = 2'd0;
  localparam logic [1:0] FUNC_CANCEL = 2'd1;
  localparam logic [1:0] FUNC_MODIFY = 2'd2;

  typedef enum logic [2:0] {
    CODE_RESTING   = 3'd0,
    CODE_PARTIAL   = 3'd1,
    CODE_FILLED    = 3'd2,
    CODE_CANCELLED = 3'd3,
    CODE_MODIFIED  = 3'd4,
    CODE_REJECTED  = 3'd5,
    CODE_BOOK_FULL = 3'd6
  } code_e;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_FILL   = 3'd1,
    CMD_CLEAR  = 3'd2,
    CMD_MODIFY = 3'd3,
    CMD_WRITE  = 3'd4
  } cmd_op_e;

  typedef struct packed {
    logic        side;
    logic [31:0] price;
    logic [23:0] orig;
    logic [23:0] rem;
    logic [31:0] oid;
    logic [31:0] coid;
    logic [15:0] cid;
    logic [15:0] conn;
    logic [31:0] arrival;
  } slot_t;

  typedef struct packed {
    logic        found;
    idx_t        idx;
    logic [31:0] age;
    slot_t       rec;
    logic        free_found;
    idx_t        free_idx;
  } tok_t;

  typedef struct packed {
    logic        find;
    logic        side;
    logic [31:0] price;
    logic [31:0] coid;
    logic [31:0] arrival;
  } key_t;

  typedef struct packed {
    cmd_op_e op;
    idx_t    idx;
    slot_t   rec;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] oid;
    logic [31:0] coid;
    logic [15:0] cid;
    logic [15:0] conn;
    logic        side;
    logic [31:0] price;
    logic [23:0] qty;
  } item_t;

  typedef struct packed {
    logic        kind;
    code_e       code;
    logic [31:0] trade;
    logic [31:0] oid;
    logic [31:0] coid;
    logic [15:0] cid;
    logic [15:0] conn;
    logic        side;
    logic [31:0] price;
    logic [23:0] qty;
    logic [23:0] amount;
    logic        last;
  } row_t;

endpackage

@@ hdl/lobm_cell.sv @@
// One order slot of the book and one stage of the search chain.
`timescale 1ns / 1ps
`include "limit_order_book_matcher_defines.svh"
module lobm_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lobm_pkg::idx_t idx_i,
  input  lobm_pkg::key_t key_i,
  input  lobm_pkg::cmd_t cmd_i,
  input  logic           tok_vld_i,
  input  lobm_pkg::tok_t tok_i,
  output logic           tok_vld_o,
  output lobm_pkg::tok_t tok_o
);

  logic           valid_q;
  lobm_pkg::slot_t rec_q;
  logic           tok_vld_q;
  lobm_pkg::tok_t tok_q, tok_d;
  logic [31:0]    age;
  logic           elig, better, crosses, pbetter, hit;

  assign age = key_i.arrival - rec_q.arrival;
  assign hit = (cmd_i.idx == idx_i);

  always_comb begin
    crosses = key_i.side ? (rec_q.price >= key_i.price) : (rec_q.price <= key_i.price);
    pbetter = key_i.side ? (rec_q.price > tok_i.rec.price) : (rec_q.price < tok_i.rec.price);
    if (key_i.find) begin
      elig   = valid_q && (rec_q.coid == key_i.coid);
      better = !tok_i.found || (age < tok_i.age);
    end else begin
      elig   = valid_q && (rec_q.side != key_i.side) && crosses;
      better = !tok_i.found ||
               ((rec_q.price != tok_i.rec.price) ? pbetter : (age > tok_i.age));
    end
    tok_d = tok_i;
    if (elig && better) begin
      tok_d.found = 1'b1;
      tok_d.idx   = idx_i;
      tok_d.age   = age;
      tok_d.rec   = rec_q;
    end
    if (!tok_i.free_found && !valid_q) begin
      tok_d.free_found = 1'b1;
      tok_d.free_idx   = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_vld_i;
      if (hit) begin
        unique case (cmd_i.op)
          lobm_pkg::CMD_WRITE: valid_q <= 1'b1;
          lobm_pkg::CMD_CLEAR: valid_q <= 1'b0;
          lobm_pkg::CMD_FILL: begin
            if (cmd_i.rec.rem == '0) valid_q <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    if (hit) begin
      unique case (cmd_i.op)
        lobm_pkg::CMD_WRITE: rec_q <= cmd_i.rec;
        lobm_pkg::CMD_FILL:  rec_q.rem <= cmd_i.rec.rem;
        lobm_pkg::CMD_MODIFY: begin
          rec_q.orig <= cmd_i.rec.orig;
          rec_q.rem  <= cmd_i.rec.rem;
        end
        default: ;
      endcase
    end
  end

  assign tok_vld_o = tok_vld_q;
  assign tok_o     = tok_q;

  `LOBM_ASSERT(a_write_free, clk_i, rst_ni,
               (cmd_i.op == lobm_pkg::CMD_WRITE && hit) |-> !valid_q, "write to an occupied slot")
  `LOBM_ASSERT(a_tok_step, clk_i, rst_ni, tok_vld_i |=> tok_vld_o, "token lost in a cell")
  `LOBM_ASSERT(a_free_kept, clk_i, rst_ni,
               (tok_vld_i && tok_i.free_found) |=> tok_o.free_found, "free slot mark dropped")

endmodule

@@ hdl/lobm_ctrl.sv @@
// Sequencer: launches searches, decides fills and status rows, owns the output register.
`timescale 1ns / 1ps
`include "limit_order_book_matcher_defines.svh"
module lobm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  lobm_pkg::item_t item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output lobm_pkg::row_t  row_o,
  output lobm_pkg::key_t  key_o,
  output lobm_pkg::cmd_t  cmd_o,
  output logic            launch_o,
  input  logic            tok_end_vld_i,
  input  lobm_pkg::tok_t  tok_end_i
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_ACT  = 3'b100
  } state_e;

  state_e          state_q;
  logic            launch_q;
  lobm_pkg::item_t it_q;
  logic [23:0]     rem_q;
  logic            filled_q;
  logic [31:0]     arrival_q, trade_q;
  lobm_pkg::tok_t  res_q;
  logic            out_vld_q;
  lobm_pkg::row_t  out_q;

  lobm_pkg::row_t  row;
  lobm_pkg::cmd_t  cmd;
  logic            act_scan, arr_inc, ok;
  logic [23:0]     fill_amt, left_amt;
  logic            in_acc, can_load, load;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign can_load   = !out_vld_q || out_ready_i;
  assign load       = (state_q == S_ACT) && can_load;

  assign fill_amt = (rem_q < res_q.rec.rem) ? rem_q : res_q.rec.rem;
  assign left_amt = res_q.rec.rem - fill_amt;

  always_comb begin
    row      = '0;
    cmd      = '0;
    cmd.op   = lobm_pkg::CMD_NONE;
    act_scan = 1'b0;
    arr_inc  = 1'b0;
    ok       = 1'b0;
    row.kind = 1'b1;
    row.last = 1'b1;
    row.code = lobm_pkg::CODE_REJECTED;
    if (it_q.func == lobm_pkg::FUNC_NEW) begin
      row.oid    = it_q.oid;
      row.coid   = it_q.coid;
      row.cid    = it_q.cid;
      row.side   = it_q.side;
      row.price  = it_q.price;
      row.qty    = it_q.qty;
      row.amount = rem_q;
      if (rem_q == '0) begin
        row.code = lobm_pkg::CODE_FILLED;
      end else if (res_q.found) begin
        // Fill against the best resting order, then search again.
        row.kind   = 1'b0;
        row.last   = 1'b0;
        row.code   = (left_amt == '0) ? lobm_pkg::CODE_FILLED : lobm_pkg::CODE_PARTIAL;
        row.trade  = trade_q;
        row.oid    = res_q.rec.oid;
        row.coid   = res_q.rec.coid;
        row.cid    = res_q.rec.cid;
        row.conn   = res_q.rec.conn;
        row.side   = res_q.rec.side;
        row.price  = res_q.rec.price;
        row.qty    = res_q.rec.orig;
        row.amount = fill_amt;
        cmd.op      = lobm_pkg::CMD_FILL;
        cmd.idx     = res_q.idx;
        cmd.rec.rem = left_amt;
        act_scan    = 1'b1;
      end else if (res_q.free_found) begin
        row.code = filled_q ? lobm_pkg::CODE_PARTIAL : lobm_pkg::CODE_RESTING;
        cmd.op          = lobm_pkg::CMD_WRITE;
        cmd.idx         = res_q.free_idx;
        cmd.rec.side    = it_q.side;
        cmd.rec.price   = it_q.price;
        cmd.rec.orig    = it_q.qty;
        cmd.rec.rem     = rem_q;
        cmd.rec.oid     = it_q.oid;
        cmd.rec.coid    = it_q.coid;
        cmd.rec.cid     = it_q.cid;
        cmd.rec.conn    = it_q.conn;
        cmd.rec.arrival = arrival_q;
        arr_inc         = 1'b1;
      end else begin
        row.code = lobm_pkg::CODE_BOOK_FULL;
      end
    end else begin
      ok = ((it_q.func == lobm_pkg::FUNC_CANCEL) || (it_q.func == lobm_pkg::FUNC_MODIFY)) &&
           res_q.found && (res_q.rec.cid == it_q.cid) &&
           !((it_q.func == lobm_pkg::FUNC_MODIFY) && (it_q.qty == '0));
      row.coid = it_q.coid;
      row.cid  = it_q.cid;
      if (ok) begin
        row.oid    = res_q.rec.oid;
        row.coid   = res_q.rec.coid;
        row.cid    = res_q.rec.cid;
        row.side   = res_q.rec.side;
        row.price  = res_q.rec.price;
        row.qty    = res_q.rec.orig;
        cmd.idx    = res_q.idx;
        if (it_q.func == lobm_pkg::FUNC_CANCEL) begin
          row.code = lobm_pkg::CODE_CANCELLED;
          cmd.op   = lobm_pkg::CMD_CLEAR;
        end else if (it_q.qty >= res_q.rec.rem) begin
          row.amount = res_q.rec.rem;
        end else begin
          row.code     = lobm_pkg::CODE_MODIFIED;
          row.qty      = it_q.qty;
          row.amount   = it_q.qty;
          cmd.op       = lobm_pkg::CMD_MODIFY;
          cmd.rec.orig = it_q.qty;
          cmd.rec.rem  = it_q.qty;
        end
      end
    end
  end

  always_comb begin
    cmd_o = cmd;
    if (!load) cmd_o.op = lobm_pkg::CMD_NONE;
  end

  assign key_o.find    = (it_q.func != lobm_pkg::FUNC_NEW);
  assign key_o.side    = it_q.side;
  assign key_o.price   = it_q.price;
  assign key_o.coid    = it_q.coid;
  assign key_o.arrival = arrival_q;
  assign launch_o      = launch_q;
  assign out_valid_o   = out_vld_q;
  assign row_o         = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      launch_q  <= 1'b0;
      filled_q  <= 1'b0;
      arrival_q <= '0;
      trade_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      launch_q <= 1'b0;
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q  <= S_SCAN;
            launch_q <= 1'b1;
            filled_q <= 1'b0;
          end
        end
        S_SCAN: begin
          if (tok_end_vld_i) state_q <= S_ACT;
        end
        S_ACT: begin
          if (load) begin
            if (act_scan) begin
              state_q  <= S_SCAN;
              launch_q <= 1'b1;
              filled_q <= 1'b1;
              trade_q  <= trade_q + 32'd1;
            end else begin
              state_q <= S_IDLE;
            end
            if (arr_inc) arrival_q <= arrival_q + 32'd1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      it_q  <= item_i;
      rem_q <= item_i.qty;
    end
    if (state_q == S_SCAN && tok_end_vld_i) res_q <= tok_end_i;
    if (load) begin
      out_q <= row;
      if (act_scan) rem_q <= rem_q - fill_amt;
    end
  end

  `LOBM_ASSERT(a_accept_scan, clk_i, rst_ni, in_acc |=> (state_q == S_SCAN && launch_q), "accepted item did not start a search")
  `LOBM_ASSERT_NEVER(a_tok_idle, clk_i, rst_ni, tok_end_vld_i && state_q != S_SCAN, "search result outside a search")
  `LOBM_ASSERT(a_load_free, clk_i, rst_ni, load |-> (!out_vld_q || out_ready_i), "output register overwritten")
  `LOBM_ASSERT(a_rem_down, clk_i, rst_ni, ($past(state_q) != S_IDLE) |-> (rem_q <= $past(rem_q)), "remaining quantity grew")

endmodule

@@ hdl/limit_order_book_matcher.sv @@
// Top level of the one-symbol price-time priority limit order book matcher.
//
//   Channel   Direction  Handshake                    Contents
//   s_axis    in         s_axis_tvalid/s_axis_tready  one request (new, cancel, modify)
//   m_axis    out        m_axis_tvalid/m_axis_tready  fill rows and one status row
//   cfg       in         cfg_valid_i/cfg_ready_o      book symbol register
//
// Every search walks one token down a chain of ORDER_SLOTS cells, one cell a
// cycle, and the sequencer decides once the token leaves the last cell. A new
// order searches again after each fill; a cancel or modify searches once.
// One request is worked at a time; s_axis_tready is high only while idle.
// A result beat waits in the output register; the sequencer stalls there until
// m_axis_tready frees it, and the book is not touched while it waits.
// Reset is asynchronous and active low; it empties the book and clears both
// the arrival and the trade counter. No clearing pass is needed.
`timescale 1ns / 1ps
module limit_order_book_matcher (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Request beat.
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // oid[31:0], coid[63:32], cid[79:64], conn[95:80],
  // side[96], price[128:97], qty[152:129], zero pad above.
  input  logic [159:0] s_axis_tdata,
  // func[1:0].
  input  logic [1:0]   s_axis_tuser,
  // Result beat.
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // code[2:0], trade_number[34:3], row_oid[66:35],
  // row_coid[98:67], row_cid[114:99], row_conn[130:115],
  // row_side[131], row_price[163:132], row_qty[187:164], row_amount[211:188],
  // zero pad above.
  output logic [215:0] m_axis_tdata,
  // kind[0].
  output logic         m_axis_tuser,
  output logic         m_axis_tlast,
  // Configuration write.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [15:0]  cfg_data_i
);

  localparam int unsigned N = lobm_pkg::ORDER_SLOTS;

  lobm_pkg::item_t item;
  lobm_pkg::row_t  row;
  lobm_pkg::key_t  key;
  lobm_pkg::cmd_t  cmd;
  logic            launch;
  logic            tok_vld [N+1];
  lobm_pkg::tok_t  tok     [N+1];
  logic [15:0]     book_symbol_q;

  // The symbol is held for the host; no result field carries it.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      book_symbol_q <= '0;
    end else if (cfg_valid_i) begin
      book_symbol_q <= cfg_data_i;
    end
  end

  assign item.func  = s_axis_tuser;
  assign item.oid   = s_axis_tdata[31:0];
  assign item.coid  = s_axis_tdata[63:32];
  assign item.cid   = s_axis_tdata[79:64];
  assign item.conn  = s_axis_tdata[95:80];
  assign item.side  = s_axis_tdata[96];
  assign item.price = s_axis_tdata[128:97];
  assign item.qty   = s_axis_tdata[152:129];

  // Each search starts empty: nothing found, no free slot seen yet.
  assign tok_vld[0] = launch;
  assign tok[0]     = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    lobm_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .idx_i     (lobm_pkg::idx_t'(i)),
      .key_i     (key),
      .cmd_i     (cmd),
      .tok_vld_i (tok_vld[i]),
      .tok_i     (tok[i]),
      .tok_vld_o (tok_vld[i+1]),
      .tok_o     (tok[i+1])
    );
  end

  lobm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .item_i        (item),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .row_o         (row),
    .key_o         (key),
    .cmd_o         (cmd),
    .launch_o      (launch),
    .tok_end_vld_i (tok_vld[N]),
    .tok_end_i     (tok[N])
  );

  assign m_axis_tuser = row.kind;
  assign m_axis_tlast = row.last;
  assign m_axis_tdata = {4'b0, row.amount, row.qty, row.price, row.side, row.conn,
                         row.cid, row.coid, row.oid, row.trade, row.code};

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the limit order book matcher.
`timescale 1ns / 1ps
module tb_top;
  import lobm_pkg::*;

  localparam int          NSLOT       = ORDER_SLOTS;
  localparam logic [1:0]  FUNC_UNUSED = 2'd3;
  localparam int          IDLE_LIMIT  = 20000;
  localparam int          HOLD_CYCLES = 400;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [215:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [15:0]  cfg_data_i = '0;

  limit_order_book_matcher dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  // 12 ns clock period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the book that the predictor keeps in step with the block.
  logic        bk_valid [NSLOT];
  logic        bk_side  [NSLOT];
  logic [31:0] bk_price [NSLOT];
  logic [23:0] bk_orig  [NSLOT];
  logic [23:0] bk_rem   [NSLOT];
  logic [31:0] bk_oid   [NSLOT];
  logic [31:0] bk_coid  [NSLOT];
  logic [15:0] bk_cid   [NSLOT];
  logic [15:0] bk_conn  [NSLOT];
  logic [31:0] bk_arr   [NSLOT];
  logic [31:0] arrival_seq = '0;
  logic [31:0] trade_seq = '0;
  logic [15:0] symbol_reg = '0;  // Stored by the block but never visible in a row.

  row_t expected_rows[$];
  int   error_count = 0;
  int   items_sent = 0;
  int   rows_seen = 0;
  int   fills_seen = 0;
  int   full_seen = 0;
  int   idle_cycles = 0;
  int   burst_left = 0;
  bit   hold_off = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic queue_row(input row_t r);
    expected_rows.insert(expected_rows.size(), r);
  endtask

  // Best resting order on the opposite side that crosses the given limit:
  // best price first, then the oldest arrival.
  function automatic int best_match(input logic side, input logic [31:0] price);
    int best;
    logic [31:0] best_age, age;
    logic better;
    best = -1;
    best_age = '0;
    for (int i = 0; i < NSLOT; i++) begin
      if (!bk_valid[i] || bk_side[i] == side) continue;
      if (side == 1'b0 ? (bk_price[i] > price) : (bk_price[i] < price)) continue;
      age = arrival_seq - bk_arr[i];
      if (best < 0) better = 1'b1;
      else if (bk_price[i] != bk_price[best])
        better = (side == 1'b0) ? (bk_price[i] < bk_price[best]) : (bk_price[i] > bk_price[best]);
      else better = (age > best_age);
      if (better) begin
        best = i;
        best_age = age;
      end
    end
    return best;
  endfunction

  // Duplicate client order ids resolve to the most recent arrival.
  function automatic int lookup_coid(input logic [31:0] coid);
    int best;
    logic [31:0] best_age, age;
    best = -1;
    best_age = '0;
    for (int i = 0; i < NSLOT; i++) begin
      if (!bk_valid[i] || bk_coid[i] != coid) continue;
      age = arrival_seq - bk_arr[i];
      if (best < 0 || age < best_age) begin
        best = i;
        best_age = age;
      end
    end
    return best;
  endfunction

  function automatic row_t slot_status(input int s, input code_e code, input logic [23:0] amt);
    row_t r;
    r = '{kind: 1'b1, code: code, trade: '0, oid: bk_oid[s], coid: bk_coid[s],
          cid: bk_cid[s], conn: '0, side: bk_side[s], price: bk_price[s],
          qty: bk_orig[s], amount: amt, last: 1'b1};
    return r;
  endfunction

  // Works out every row that one accepted request causes and updates the book.
  task automatic predict_rows(input item_t it);
    row_t r;
    int s, f, nfill;
    logic [23:0] rem, fill;
    code_e code;
    nfill = 0;
    if (it.func == FUNC_NEW) begin
      rem = it.qty;
      while (rem != 0) begin
        s = best_match(it.side, it.price);
        if (s < 0) break;
        fill = (rem < bk_rem[s]) ? rem : bk_rem[s];
        rem -= fill;
        bk_rem[s] -= fill;
        r = '{kind: 1'b0, code: (bk_rem[s] == 0) ? CODE_FILLED : CODE_PARTIAL,
              trade: trade_seq, oid: bk_oid[s], coid: bk_coid[s], cid: bk_cid[s],
              conn: bk_conn[s], side: bk_side[s], price: bk_price[s], qty: bk_orig[s],
              amount: fill, last: 1'b0};
        queue_row(r);
        trade_seq++;
        nfill++;
        if (bk_rem[s] == 0) bk_valid[s] = 1'b0;
      end
      if (rem == 0) code = CODE_FILLED;
      else begin
        f = -1;
        for (int i = 0; i < NSLOT; i++)
          if (!bk_valid[i] && f < 0) f = i;
        if (f < 0) code = CODE_BOOK_FULL;
        else begin
          bk_valid[f] = 1'b1;
          bk_side[f]  = it.side;
          bk_price[f] = it.price;
          bk_orig[f]  = it.qty;
          bk_rem[f]   = rem;
          bk_oid[f]   = it.oid;
          bk_coid[f]  = it.coid;
          bk_cid[f]   = it.cid;
          bk_conn[f]  = it.conn;
          bk_arr[f]   = arrival_seq;
          arrival_seq++;
          code = (nfill > 0) ? CODE_PARTIAL : CODE_RESTING;
        end
      end
      r = '{kind: 1'b1, code: code, trade: '0, oid: it.oid, coid: it.coid, cid: it.cid,
            conn: '0, side: it.side, price: it.price, qty: it.qty, amount: rem, last: 1'b1};
      queue_row(r);
      return;
    end
    s = (it.func == FUNC_UNUSED) ? -1 : lookup_coid(it.coid);
    if (it.func == FUNC_MODIFY && it.qty == 0) s = -1;
    if (s >= 0 && bk_cid[s] != it.cid) s = -1;
    if (s < 0) begin
      r = '{kind: 1'b1, code: CODE_REJECTED, trade: '0, oid: '0, coid: it.coid, cid: it.cid,
            conn: '0, side: 1'b0, price: '0, qty: '0, amount: '0, last: 1'b1};
      queue_row(r);
    end else if (it.func == FUNC_CANCEL) begin
      bk_valid[s] = 1'b0;
      queue_row(slot_status(s, CODE_CANCELLED, '0));
    end else if (it.qty >= bk_rem[s]) begin
      queue_row(slot_status(s, CODE_REJECTED, bk_rem[s]));
    end else begin
      bk_orig[s] = it.qty;
      bk_rem[s]  = it.qty;
      queue_row(slot_status(s, CODE_MODIFIED, it.qty));
    end
  endtask

  // Sends one request beat. Within a burst tvalid stays high from one beat
  // to the next; before a new burst it may drop for a random gap.
  task automatic send_item(input item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 10);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.func;
    s_axis_tdata  <= {7'b0, it.qty, it.price, it.side, it.conn, it.cid, it.coid, it.oid};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_rows(it);
    items_sent++;
    burst_left--;
  endtask

  function automatic item_t new_order(input logic [31:0] oid, coid, input logic [15:0] cid,
                                      conn, input logic side, input logic [31:0] price,
                                      input logic [23:0] qty);
    item_t it;
    it = '{func: FUNC_NEW, oid: oid, coid: coid, cid: cid, conn: conn, side: side,
           price: price, qty: qty};
    return it;
  endfunction

  function automatic item_t request(input logic [1:0] func, input logic [31:0] coid,
                                    input logic [15:0] cid, input logic [23:0] qty);
    item_t it;
    it = '{func: func, oid: $urandom, coid: coid, cid: cid, conn: 16'($urandom),
           side: 1'($urandom), price: $urandom, qty: qty};
    return it;
  endfunction

  // Waits until every expected row has come back and the block is idle again.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_rows.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_symbol(input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    symbol_reg = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver: the stall pattern changes in turn between always ready, a coin
  // toss and ready with a one-in-four chance. A hold-off overrides it.
  int rx_cycle = 0;
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (hold_off) m_axis_tready <= 1'b0;
    else case ((rx_cycle / 64) % 3)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Checker: compares each accepted result beat with the oldest expected row.
  always @(posedge clk_i) begin
    row_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{kind: m_axis_tuser, code: code_e'(m_axis_tdata[2:0]),
              trade: m_axis_tdata[34:3], oid: m_axis_tdata[66:35],
              coid: m_axis_tdata[98:67], cid: m_axis_tdata[114:99],
              conn: m_axis_tdata[130:115], side: m_axis_tdata[131],
              price: m_axis_tdata[163:132], qty: m_axis_tdata[187:164],
              amount: m_axis_tdata[211:188], last: m_axis_tlast};
      rows_seen++;
      if (expected_rows.size() == 0) report_mismatch("result beat with nothing expected");
      else begin
        want = expected_rows.pop_front();
        if (!want.kind) fills_seen++;
        if (want.code == CODE_BOOK_FULL) full_seen++;
        if (got.kind !== want.kind)
          report_mismatch($sformatf("kind %0h, expected %0h", got.kind, want.kind));
        if (got.code !== want.code)
          report_mismatch($sformatf("code %0d, expected %0d", got.code, want.code));
        if (got.trade !== want.trade)
          report_mismatch($sformatf("trade %0h, expected %0h", got.trade, want.trade));
        if (got.oid !== want.oid)
          report_mismatch($sformatf("order id %0h, expected %0h", got.oid, want.oid));
        if (got.coid !== want.coid)
          report_mismatch($sformatf("client order id %0h, expected %0h", got.coid, want.coid));
        if (got.cid !== want.cid)
          report_mismatch($sformatf("client id %0h, expected %0h", got.cid, want.cid));
        if (got.conn !== want.conn)
          report_mismatch($sformatf("conn id %0h, expected %0h", got.conn, want.conn));
        if (got.side !== want.side)
          report_mismatch($sformatf("side %0h, expected %0h", got.side, want.side));
        if (got.price !== want.price)
          report_mismatch($sformatf("price %0h, expected %0h", got.price, want.price));
        if (got.qty !== want.qty)
          report_mismatch($sformatf("qty %0h, expected %0h", got.qty, want.qty));
        if (got.amount !== want.amount)
          report_mismatch($sformatf("amount %0h, expected %0h", got.amount, want.amount));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %0h, expected %0h", got.last, want.last));
      end
    end
  end

  // Watchdog: ends the run when no beat moves on any channel for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Directed cases: resting, crossing with partial and full fills, price and
  // quantity extremes, zero quantity, cancel and modify in every outcome,
  // duplicate client order ids and the unused function code.
  task automatic test_directed;
    send_item(new_order(32'h1, 32'hA, 16'h1, 16'hFFFF, 1'b0, 32'd100, 24'd10));
    send_item(new_order(32'h2, 32'hB, 16'h2, 16'h0001, 1'b0, 32'd100, 24'd5));
    send_item(new_order(32'h3, 32'hC, 16'h3, 16'h0002, 1'b1, 32'd90, 24'd12));
    send_item(new_order(32'h4, 32'hD, 16'h3, 16'h0003, 1'b1, 32'd100, 24'd20));
    send_item(new_order(32'h5, 32'hE, 16'h4, 16'h0004, 1'b0, 32'd99, 24'd0));
    send_item(new_order(32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
                        32'hFFFFFFFF, 24'hFFFFFF));
    send_item(new_order(32'h6, 32'hF, 16'h5, 16'h0, 1'b0, 32'h0, 24'd7));
    send_item(new_order(32'h7, 32'hF, 16'h5, 16'h5, 1'b0, 32'h1, 24'd9));
    send_item(request(FUNC_MODIFY, 32'hF, 16'h5, 24'd3));
    send_item(request(FUNC_MODIFY, 32'hF, 16'h5, 24'd3));
    send_item(request(FUNC_MODIFY, 32'hF, 16'h5, 24'd0));
    send_item(request(FUNC_MODIFY, 32'hF, 16'h6, 24'd1));
    send_item(request(FUNC_CANCEL, 32'hF, 16'h6, 24'd0));
    send_item(request(FUNC_CANCEL, 32'hF, 16'h5, 24'd0));
    send_item(request(FUNC_CANCEL, 32'hF, 16'h5, 24'd0));
    send_item(request(FUNC_CANCEL, 32'h12345678, 16'h1, 24'd0));
    send_item(request(FUNC_UNUSED, 32'hD, 16'h3, 24'd1));
    send_item(new_order(32'h8, 32'h10, 16'h7, 16'h7, 1'b0, 32'hFFFFFFFF, 24'hFFFFFF));
    send_item(new_order(32'h9, 32'h11, 16'h8, 16'h8, 1'b1, 32'h0, 24'hFFFFFF));
    drain();
  endtask

  // Sends a bid for every slot, one bid more and one sweeping sell, aimed at a full
  // book; the sell that the directed cases leave resting at price zero fills the bids.
  task automatic test_book_full;
    for (int i = 0; i < NSLOT; i++)
      send_item(new_order(32'h100 + i, 32'h200 + i, 16'h9, 16'(i), 1'b0, 32'd1000 + i,
                          24'd2));
    send_item(new_order(32'h300, 32'h301, 16'h9, 16'h9, 1'b0, 32'd5, 24'd4));
    send_item(new_order(32'h302, 32'h303, 16'hA, 16'hA, 1'b1, 32'd0, 24'd1000));
    drain();
  endtask

  // Random requests: mostly new orders around a mid price plus cancels and
  // modifies on a small pool of ids, with some raw values on every field.
  task automatic test_random(input int count);
    item_t it;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)
        it = new_order($urandom, $urandom_range(1, 24), 16'($urandom_range(1, 4)),
                       16'($urandom), 1'($urandom_range(0, 1)),
                       32'd500 + $urandom_range(0, 20), 24'($urandom_range(1, 40)));
      else if (pick < 75)
        it = request(FUNC_CANCEL, $urandom_range(1, 24), 16'($urandom_range(1, 4)),
                     24'($urandom));
      else if (pick < 90)
        it = request(FUNC_MODIFY, $urandom_range(1, 24), 16'($urandom_range(1, 4)),
                     24'($urandom_range(0, 30)));
      else begin
        it = request(2'($urandom_range(0, 3)), $urandom, 16'($urandom), 24'($urandom));
        it.oid = $urandom;
      end
      send_item(it);
    end
    drain();
  endtask

  // The receiver holds off for a long stretch while requests keep coming,
  // so the output register fills and the request side stalls.
  task automatic test_backpressure;
    fork
      begin
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join_none
    test_random(20);
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) bk_valid[i] = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_symbol(16'h0000);
    test_directed();
    write_symbol(16'hFFFF);
    test_book_full();
    write_symbol(16'($urandom));
    test_random(60);
    write_symbol(16'h8000);
    test_backpressure();
    write_symbol(16'($urandom));
    test_random(50);
    $display("Covered %0d requests, %0d result rows, %0d fills, %0d book-full answers.",
             items_sent, rows_seen, fills_seen, full_seen);
    $display("Symbol writes went through zero, all ones and random values (last %0h); %0d %s",
             symbol_reg, error_count, "mismatches.");
    if (error_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ limit_order_book_matcher.f @@
+incdir+hdl
hdl/lobm_pkg.sv
hdl/lobm_cell.sv
hdl/lobm_ctrl.sv
hdl/limit_order_book_matcher.sv
tb/sv/tb_top.sv
